[rtl/core/poly_pkg.sv]
// ----------------------------------------------------------------------------
// poly_pkg
// Shared widths, formats and defaults for the Horner polynomial evaluator.
// ----------------------------------------------------------------------------
package poly_pkg;

  // Q16.16 data format
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  // full product and post-shift sum widths
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W - FRAC_BITS + 1;

  // coefficient register file
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // default number of coefficients in use
  localparam int NUM_TERMS_DEF = 8;

  typedef logic signed [DATA_W-1:0]    data_t;
  typedef logic [REG_IDX_W-1:0]        reg_idx_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

endpackage

[rtl/core/polynomial_evaluator.sv]
// Path: each accepted item is registered in acc stage 0, then passes through
//   a multiply stage and a shift/add/saturate stage per Horner step.
// Throughput: one item per cycle while out_stall is low; each Horner step owns
//   a multiply stage and a shift/add/saturate stage, so no unit is shared between items.
// Reset: synchronous, active low; clears every stage valid bit and all eight
//   coefficient registers to zero.
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Pipelined Horner evaluation of a degree <= 7 polynomial in signed Q16.16.
// ----------------------------------------------------------------------------
module polynomial_evaluator #(
  parameter int NUM_TERMS = poly_pkg::NUM_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  // coefficient write port
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  poly_pkg::reg_idx_t cfg_index,
  input  poly_pkg::data_t    cfg_data,

  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  poly_pkg::data_t    in_x_value,

  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output poly_pkg::data_t    out_y_value,
  output logic               out_overflow
);
  import poly_pkg::*;

  // Horner steps: one multiply-accumulate per coefficient below the top one
  localparam int STEPS = NUM_TERMS - 1;

  // --------------------------------------------------------------------------
  // Coefficient registers. All eight are kept; only the low NUM_TERMS feed the
  // datapath. The user writes only while the pipeline is empty (not enforced).
  // --------------------------------------------------------------------------
  data_t coef_r [NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline registers.
  //   acc stage k (k = 0..STEPS): accumulator after k steps and flag, plus x below STEPS.
  //   prod stage j (j = 0..STEPS-1): full 64-bit product of step j.
  // Acc stage STEPS is the output register.
  // --------------------------------------------------------------------------
  logic  va_r  [STEPS+1];
  logic  ova_r [STEPS+1];
  data_t acc_r [STEPS+1];
  data_t xa_r  [STEPS];

  logic  vp_r  [STEPS];
  logic  ovp_r [STEPS];
  prod_t prod_r[STEPS];
  data_t xp_r  [STEPS];

  // stage may load when it is empty or its content moves on this cycle
  logic  rdy_a [STEPS+1];
  logic  rdy_p [STEPS];

  // per-step shifted sum and its saturation
  sum_t  sum_w   [STEPS];
  logic  sat_hi_w[STEPS];
  logic  sat_lo_w[STEPS];
  data_t acc_nxt [STEPS];

  assign rdy_a[STEPS] = !va_r[STEPS] || !out_stall;

  // Stage 0: take the item and seed the accumulator with the top coefficient
  assign in_stall = !rdy_a[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r[0] <= 1'b0;
    end else if (rdy_a[0]) begin
      va_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a[0]) begin
      acc_r[0] <= coef_r[NUM_TERMS-1];
      xa_r[0]  <= in_x_value;
      ova_r[0] <= 1'b0;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    // coefficient added by this step
    localparam int DEG = NUM_TERMS - 2 - j;

    assign rdy_p[j] = !vp_r[j] || rdy_a[j+1];
    assign rdy_a[j] = !va_r[j] || rdy_p[j];

    // multiply stage: exact signed 32x32 product
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vp_r[j] <= 1'b0;
      end else if (rdy_p[j]) begin
        vp_r[j] <= va_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (va_r[j] && rdy_p[j]) begin
        prod_r[j] <= $signed(acc_r[j]) * $signed(xa_r[j]);
        ovp_r[j]  <= ova_r[j];
        xp_r[j]   <= xa_r[j];
      end
    end

    // floor shift, add coefficient, clamp to 32 bits
    always_comb begin
      sum_w[j] = SUM_W'(prod_r[j] >>> FRAC_BITS) + SUM_W'(coef_r[DEG]);
      sat_hi_w[j] = !sum_w[j][SUM_W-1] && (|sum_w[j][SUM_W-2:DATA_W-1]);
      sat_lo_w[j] = sum_w[j][SUM_W-1] && !(&sum_w[j][SUM_W-2:DATA_W-1]);
      priority if (sat_hi_w[j]) begin
        acc_nxt[j] = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sat_lo_w[j]) begin
        acc_nxt[j] = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        acc_nxt[j] = sum_w[j][DATA_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j+1] <= 1'b0;
      end else if (rdy_a[j+1]) begin
        va_r[j+1] <= vp_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (vp_r[j] && rdy_a[j+1]) begin
        acc_r[j+1] <= acc_nxt[j];
        ova_r[j+1] <= ovp_r[j] || sat_hi_w[j] || sat_lo_w[j];
      end
    end

    // carry x forward for the next multiply
    if (j < STEPS - 1) begin : g_xfwd
      always_ff @(posedge clk) begin
        if (vp_r[j] && rdy_a[j+1]) begin
          xa_r[j+1] <= xp_r[j];
        end
      end
    end else begin : g_xlast
      // last step needs no x after its multiply
      logic unused_x;
      assign unused_x = ^xp_r[j];
    end
  end

  assign out_valid    = va_r[STEPS];
  assign out_y_value  = acc_r[STEPS];
  assign out_overflow = ova_r[STEPS];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // input stalls only when the first stage holds an item that cannot move
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (va_r[0] && !rdy_p[0]))
    else $error("input stalled with a free first stage");

  // a saturated first step clamps the accumulator and raises the flag
  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (vp_r[0] && rdy_a[1] && (sat_hi_w[0] || sat_lo_w[0])) |=>
      (ova_r[1] && (acc_r[1] == {1'b0, {(DATA_W-1){1'b1}}} ||
                    acc_r[1] == {1'b1, {(DATA_W-1){1'b0}}})))
    else $error("saturation not clamped or not flagged");

  // overflow flag is sticky across the multiply stage
  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r[0] && rdy_p[0] && ova_r[0]) |=> ovp_r[0])
    else $error("overflow flag lost in multiply stage");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result keeps the last stage from taking a new one
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !rdy_a[STEPS])
    else $error("output stage ready while result waits");

endmodule
